/* rtl/core/zhp_pkg.sv */
// ============================================================================
// zhp_pkg
// Shared types, constants and saturating Q-format helpers for the Zou-He
// pressure boundary block.
// ============================================================================
package zhp_pkg;

    localparam int W = 32;
    localparam int FRAC = 28;

    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [1:0] SIDE_RIGHT  = 2'd0;
    localparam logic [1:0] SIDE_TOP    = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_BOTTOM = 2'd3;

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TL = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    localparam logic [1:0] REG_SPEED = 2'd0;
    localparam logic [1:0] REG_BAX   = 2'd1;
    localparam logic [1:0] REG_BDG   = 2'd2;

    typedef logic signed [W-1:0] q_t;

    // populations in order R,E,N,W,S,NE,NW,SW,SE
    typedef struct packed {
        q_t         [8:0] f;
        logic [30:0]      rho;
        logic [1:0]       code;
        logic             corner;
    } node_t;

    function automatic q_t sat(input logic signed [W:0] x);
        if (x > $signed({1'b0, VMAX})) return VMAX;
        if (x < $signed({1'b1, VMIN})) return VMIN;
        return x[W-1:0];
    endfunction

    function automatic q_t sadd(input q_t a, input q_t b);
        return sat({a[W-1], a} + {b[W-1], b});
    endfunction

    function automatic q_t ssub(input q_t a, input q_t b);
        return sat({a[W-1], a} - {b[W-1], b});
    endfunction

    function automatic q_t halve(input q_t x);
        return x >>> 1;
    endfunction

    // rounded (ties away from zero) and saturated product of unsigned b and signed a
    function automatic q_t mulq(input q_t a, input logic [30:0] b);
        logic        neg;
        logic [W-1:0] ua;
        logic [62:0] p;
        logic [62:0] r;
        neg = a[W-1];
        ua  = neg ? (~a + 1'b1) : a;
        p   = ua * b + (63'd1 << (FRAC - 1));
        r   = p >> FRAC;
        if (neg)
        begin
            if (r > 63'h8000_0000) return VMIN;
            return q_t'(~r[W-1:0] + 1'b1);
        end
        if (r > 63'h7fff_ffff) return VMAX;
        return q_t'(r[W-1:0]);
    endfunction

endpackage

/* rtl/core/zhp_front.sv */
// ============================================================================
// zhp_front
// Input stage: registers a node, then computes the sums that need no
// multiply (wall-normal moment minus density, tangential half difference,
// corner mirror and the first part of the corner leftover) into a two-entry
// queue.
// ============================================================================
module zhp_front
    import zhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  node_t       in_node,
    output logic        q_valid,
    input  logic        q_ready,
    output node_t       q_node,
    output q_t          q_mom,
    output q_t          q_diff
);

    node_t in_reg;
    logic  in_valid_reg;

    // two-entry queue
    node_t       qn_reg [2];
    q_t          qm_reg [2];
    q_t          qd_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        wr_ok;
    logic        wr;
    logic        rd;

    // stage register
    assign in_ready = !in_valid_reg || wr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_node;
    end

    // classification and adds
    node_t c_node;
    q_t    c_mom;
    q_t    c_diff;
    q_t    k;
    q_t    s;
    q_t    sum;
    q_t    rho_q;
    q_t    [8:0] f;

    // corners: c_mom carries rho minus rest, east, north and west; the back
    // end subtracts the rest and places the shares
    always_comb
    begin
        f      = in_reg.f;
        rho_q  = q_t'({1'b0, in_reg.rho});
        c_node = in_reg;
        c_mom  = '0;
        c_diff = '0;
        k = '0; s = '0; sum = '0;
        if (!in_reg.corner)
        begin
            case (in_reg.code)
                SIDE_RIGHT:
                begin
                    k = sadd(sadd(f[1], f[5]), f[8]);
                    s = sadd(sadd(f[0], f[2]), f[4]);
                    sum = sadd(s, sadd(k, k));
                    c_mom = ssub(sum, rho_q);
                    c_diff = halve(ssub(f[4], f[2]));
                end
                SIDE_TOP:
                begin
                    k = sadd(sadd(f[2], f[5]), f[6]);
                    s = sadd(sadd(f[0], f[1]), f[3]);
                    sum = sadd(s, sadd(k, k));
                    c_mom = ssub(sum, rho_q);
                    c_diff = halve(ssub(f[1], f[3]));
                end
                SIDE_LEFT:
                begin
                    k = sadd(sadd(f[3], f[6]), f[7]);
                    s = sadd(sadd(f[0], f[2]), f[4]);
                    sum = sadd(s, sadd(k, k));
                    c_mom = ssub(rho_q, sum);
                    c_diff = halve(ssub(f[4], f[2]));
                end
                default:
                begin
                    k = sadd(sadd(f[4], f[7]), f[8]);
                    s = sadd(sadd(f[0], f[1]), f[3]);
                    sum = sadd(s, sadd(k, k));
                    c_mom = ssub(rho_q, sum);
                    c_diff = halve(ssub(f[3], f[1]));
                end
            endcase
        end
        else
        begin
            case (in_reg.code)
                CORNER_BL:
                begin
                    f[1] = f[3]; f[2] = f[4]; f[5] = f[7];
                end
                CORNER_BR:
                begin
                    f[3] = f[1]; f[2] = f[4]; f[6] = f[8];
                end
                CORNER_TL:
                begin
                    f[1] = f[3]; f[4] = f[2]; f[8] = f[6];
                end
                default:
                begin
                    f[3] = f[1]; f[4] = f[2]; f[7] = f[5];
                end
            endcase
            c_mom = ssub(ssub(ssub(ssub(rho_q, f[0]), f[1]), f[2]), f[3]);
            c_node.f = f;
        end
    end

    assign wr_ok = (cnt_reg != 2'd2);
    assign wr    = in_valid_reg && wr_ok;
    assign rd    = q_valid && q_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_node  = qn_reg[rp_reg];
    assign q_mom   = qm_reg[rp_reg];
    assign q_diff  = qd_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= ~wp_reg;
            if (rd)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            qn_reg[wp_reg] <= c_node;
            qm_reg[wp_reg] <= c_mom;
            qd_reg[wp_reg] <= c_diff;
        end
    end

endmodule

/* rtl/core/zhp_back.sv */
// ============================================================================
// zhp_back
// Execution pipeline: momentum multiply (or the rest of the corner leftover),
// beta multiplies, then the bounce-back rebuild and the output register.
// ============================================================================
module zhp_back
    import zhp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] speed,
    input  logic [30:0] beta_ax,
    input  logic [30:0] beta_dg,
    input  logic        q_valid,
    output logic        q_ready,
    input  node_t       q_node,
    input  q_t          q_mom,
    input  q_t          q_diff,
    output logic        out_valid,
    input  logic        out_ready,
    output q_t [8:0]    out_f
);

    logic  v1_reg, v2_reg, v3_reg;
    node_t n1_reg, n2_reg;
    q_t    d1_reg, d2_reg;
    q_t    m1_reg;
    q_t    ax_reg, dg_reg;
    q_t    lo_reg;
    q_t    [8:0] o_reg;
    logic  adv3, adv1;
    q_t    m1_next;

    // whole pipe moves as one; stalls only when the output is held
    assign adv3 = !v3_reg || out_ready;
    assign adv1 = adv3;
    assign q_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv3)
        begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // corners need no multiply: finish the leftover subtraction here
    always_comb
    begin
        if (q_node.corner)
        begin
            if (q_node.code == CORNER_BL || q_node.code == CORNER_TR)
                m1_next = ssub(ssub(ssub(q_mom, q_node.f[4]), q_node.f[5]), q_node.f[7]);
            else
                m1_next = ssub(ssub(ssub(q_mom, q_node.f[4]), q_node.f[6]), q_node.f[8]);
        end
        else
            m1_next = mulq(q_mom, speed);
    end

    q_t [8:0] g;
    q_t       ax2;

    always_comb
    begin
        g   = n2_reg.f;
        ax2 = sadd(ax_reg, ax_reg);
        if (!n2_reg.corner)
        begin
            case (n2_reg.code)
                SIDE_RIGHT:
                begin
                    g[3] = ssub(g[1], ax2);
                    g[6] = ssub(sadd(g[8], d2_reg), dg_reg);
                    g[7] = ssub(ssub(g[5], d2_reg), dg_reg);
                end
                SIDE_TOP:
                begin
                    g[4] = ssub(g[2], ax2);
                    g[7] = ssub(sadd(g[5], d2_reg), dg_reg);
                    g[8] = ssub(ssub(g[6], d2_reg), dg_reg);
                end
                SIDE_LEFT:
                begin
                    g[1] = sadd(g[3], ax2);
                    g[5] = sadd(sadd(g[7], d2_reg), dg_reg);
                    g[8] = sadd(ssub(g[6], d2_reg), dg_reg);
                end
                default:
                begin
                    g[2] = sadd(g[4], ax2);
                    g[5] = sadd(sadd(g[7], d2_reg), dg_reg);
                    g[6] = sadd(ssub(g[8], d2_reg), dg_reg);
                end
            endcase
        end
        else
        begin
            // buried diagonals get half the leftover density
            case (n2_reg.code)
                CORNER_BL, CORNER_TR:
                begin
                    g[6] = lo_reg;
                    g[8] = lo_reg;
                end
                default:
                begin
                    g[5] = lo_reg;
                    g[7] = lo_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            n1_reg <= q_node;
            d1_reg <= q_diff;
            m1_reg <= m1_next;
            n2_reg <= n1_reg;
            d2_reg <= d1_reg;
            ax_reg <= mulq(m1_reg, beta_ax);
            dg_reg <= mulq(m1_reg, beta_dg);
            lo_reg <= halve(m1_reg);
            o_reg  <= g;
        end
    end

    assign out_valid = v3_reg;
    assign out_f     = o_reg;

endmodule

/* rtl/core/zou_he_pressure_boundary_d2q9_top.sv */
// ============================================================================
// zou_he_pressure_boundary_d2q9_top
// Zou-He pressure boundary for D2Q9 nodes, Q4.28 saturating arithmetic.
// ============================================================================
// One node per cycle sustained while m_tready stays high. After an input beat
// is accepted it passes the input register, where the adds and the
// corner mirror are formed, then the two-entry queue, then three back
// stages (speed multiply or corner leftover finish, beta multiplies, rebuild)
// ending in the output register. The two multiplier stages in series set the
// depth. A stall on m_tready holds the whole back pipe; the queue and input
// register fill before s_tready drops. The user must write the registers over
// APB only while no node is in flight; the block itself does not enforce it.
module zou_he_pressure_boundary_d2q9_top
    import zhp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          s_tvalid,
    output logic          s_tready,
    // f_rest..f_southeast (9x32), density (31), boundary_side (2), zero pad (7)
    input  logic [327:0]  s_tdata,
    // is_corner
    input  logic          s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // g_rest..g_southeast, 32 bits each
    output logic [287:0]  m_tdata
);

    logic [30:0] speed_reg, bax_reg, bdg_reg;
    logic        pwr;

    assign pready = 1'b1;
    assign pwr    = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= 31'd268435456;
            bax_reg   <= 31'd89478485;
            bdg_reg   <= 31'd44739243;
        end
        else if (pwr)
        begin
            case (paddr[3:2])
                REG_SPEED: speed_reg <= pwdata[30:0];
                REG_BAX:   bax_reg   <= pwdata[30:0];
                REG_BDG:   bdg_reg   <= pwdata[30:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SPEED: prdata = {1'b0, speed_reg};
            REG_BAX:   prdata = {1'b0, bax_reg};
            REG_BDG:   prdata = {1'b0, bdg_reg};
            default:   prdata = 32'd0;
        endcase
    end

    node_t in_node;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            in_node.f[i] = s_tdata[32*i +: 32];
        in_node.rho    = s_tdata[318:288];
        in_node.code   = s_tdata[320:319];
        in_node.corner = s_tuser;
    end

    logic  q_valid, q_ready;
    node_t q_node;
    q_t    q_mom, q_diff;
    q_t    [8:0] out_f;

    zhp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_node  (in_node),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_node   (q_node),
        .q_mom    (q_mom),
        .q_diff   (q_diff)
    );

    zhp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .speed     (speed_reg),
        .beta_ax   (bax_reg),
        .beta_dg   (bdg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_node    (q_node),
        .q_mom     (q_mom),
        .q_diff    (q_diff),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_f     (out_f)
    );

    assign m_tdata = out_f;

`ifndef ASSERT_OFF
    // APB never waits
    a_cfg_pready: assert property (@(posedge clk) pready)
        else $error("pready low");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");
`endif

endmodule
